// ===== sv/serial_pixel_frame_loader_assert.svh =====
// Assertion helpers used by the checker file of the frame loader.
`ifndef SERIAL_PIXEL_FRAME_LOADER_ASSERT_SVH
`define SERIAL_PIXEL_FRAME_LOADER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define SPFL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial_pixel_frame_loader: check failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define SPFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial_pixel_frame_loader: check failed");

`endif

// ===== sv/spfl_pkg.sv =====
package spfl_pkg;

    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;

    // Register index as decoded from paddr[2].
    localparam logic REG_SYNC_VALUE = 1'b0;

    // Color pointer and channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        LINK_NORMAL = 2'd0,
        LINK_ERROR  = 2'd1,
        LINK_WAIT   = 2'd2
    } link_t;

    // Decision made for one receive event.
    typedef struct packed {
        logic       wr;
        logic       sync;
        logic [1:0] chan;
        link_t      link;
        logic       ind;
    } step_t;

endpackage

// ===== sv/spfl_ram.sv =====
module spfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/spfl_ctrl.sv =====
module spfl_ctrl #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           byte_present,
    input  logic [spfl_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           err_flag,
    input  logic [spfl_pkg::BYTE_W-1:0]    sync_value,
    output spfl_pkg::step_t                step,
    output logic [$clog2(PIXEL_COUNT)-1:0] pix,
    output logic                           pix_filled
);

    import spfl_pkg::*;

    localparam int PW = $clog2(PIXEL_COUNT);
    localparam logic [PW-1:0] LAST_PIX = PW'(PIXEL_COUNT - 1);

    link_t          link_reg, link_next, link_eff;
    logic [1:0]     color_reg, color_next;
    logic [PW-1:0]  pix_reg, pix_next;
    logic [PW:0]    fill_reg, fill_next;
    logic           ind_reg, ind_next;
    logic [BYTE_W-1:0] rcv;
    logic           is_sync;
    logic           wr;
    logic           sync;
    logic [1:0]     chan;

    assign rcv      = byte_present ? rx_byte : '0;
    assign is_sync  = (rcv == sync_value);
    // An error flag puts the link into the error state before the event is handled.
    assign link_eff = err_flag ? LINK_ERROR : link_reg;

    always_comb begin
        case (link_eff)
            LINK_WAIT: begin
                link_next = is_sync ? LINK_NORMAL : LINK_WAIT;
            end
            LINK_NORMAL: begin
                link_next = LINK_NORMAL;
            end
            default: begin
                link_next = LINK_WAIT;
            end
        endcase
    end

    always_comb begin
        wr         = 1'b0;
        sync       = 1'b0;
        chan       = CH_RED;
        ind_next   = ind_reg;
        color_next = color_reg;
        pix_next   = pix_reg;
        case (link_eff)
            LINK_WAIT: begin
                if (is_sync) begin
                    sync       = 1'b1;
                    color_next = CH_RED;
                    pix_next   = '0;
                end
            end
            LINK_NORMAL: begin
                ind_next = 1'b0;
                if (is_sync) begin
                    sync       = 1'b1;
                    color_next = CH_RED;
                    pix_next   = '0;
                end else begin
                    wr = 1'b1;
                    case (color_reg)
                        CH_GREEN: begin
                            chan       = CH_GREEN;
                            color_next = CH_BLUE;
                        end
                        CH_BLUE: begin
                            chan       = CH_BLUE;
                            color_next = CH_RED;
                            pix_next   = (pix_reg == LAST_PIX) ? '0 : pix_reg + 1'b1;
                        end
                        default: begin
                            chan       = CH_RED;
                            color_next = CH_GREEN;
                        end
                    endcase
                end
            end
            default: begin
                ind_next = 1'b1;
            end
        endcase
    end

    // Pixels are only ever written from the pointer, which never passes the
    // fill count, so every pixel below the count has been written at least once.
    assign fill_next = (wr && ({1'b0, pix_reg} == fill_reg)) ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg  <= LINK_NORMAL;
            color_reg <= CH_RED;
            pix_reg   <= '0;
            fill_reg  <= '0;
            ind_reg   <= 1'b0;
        end else if (accept) begin
            link_reg  <= link_next;
            color_reg <= color_next;
            pix_reg   <= pix_next;
            fill_reg  <= fill_next;
            ind_reg   <= ind_next;
        end
    end

    assign step.wr    = wr;
    assign step.sync  = sync;
    assign step.chan  = chan;
    assign step.link  = link_next;
    assign step.ind   = ind_next;
    assign pix        = pix_reg;
    assign pix_filled = ({1'b0, pix_reg} < fill_reg);

endmodule

// ===== sv/serial_pixel_frame_loader.sv =====
// Each accepted event passes through the stage B registers and then the result register.
// Throughput: one event per cycle while the sink does not hold back results; the frame
// store is read at acceptance and written when the event leaves stage B, through its single
// write port, with a bypass for back-to-back events on the same pixel.
// Reset (aresetn low, synchronous) clears the link state, pointers, indicator and
// fill count; the frame store then reads as zero with no clearing pass.
module serial_pixel_frame_loader #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] byte_present, [8:1] rx_byte, [9] overrun_flag, [10] framing_flag
    input  logic [spfl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] write_done, [6:1] written_pixel, [8:7] written_channel,
    // [32:9] pixel_color, [33] sync_seen, [35:34] link_status, [36] error_indicator
    output logic [spfl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spfl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spfl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spfl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    import spfl_pkg::*;

    localparam int PW = $clog2(PIXEL_COUNT);

    logic              accept;
    logic              b_adv;
    logic              in_present;
    logic [BYTE_W-1:0] in_byte;
    logic              in_err;
    logic [BYTE_W-1:0] sync_reg;
    step_t             a_step;
    logic [PW-1:0]     a_pix;
    logic              a_filled;

    logic              b_valid_reg;
    step_t             b_step_reg;
    logic [PW-1:0]     b_pix_reg;
    logic [BYTE_W-1:0] b_byte_reg;
    logic              b_filled_reg;
    logic              b_fwd_reg;
    logic              ram_we;
    logic [COLOR_W-1:0] ram_rdata;
    logic [COLOR_W-1:0] base_color;
    logic [COLOR_W-1:0] merged;
    logic [COLOR_W-1:0] last_wr_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SYNC_VALUE)) begin
            sync_reg <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SYNC_VALUE) ?
                    {{(APB_DATA_W - BYTE_W){1'b0}}, sync_reg} : '0;

    // Input side
    assign in_present = s_tdata[0];
    assign in_byte    = s_tdata[8:1];
    assign in_err     = s_tdata[9] | s_tdata[10];

    assign b_adv    = !m_valid_reg || m_tready;
    assign s_tready = !b_valid_reg || b_adv;
    assign accept   = s_tvalid && s_tready;

    spfl_ctrl #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .byte_present (in_present),
        .rx_byte      (in_byte),
        .err_flag     (in_err),
        .sync_value   (sync_reg),
        .step         (a_step),
        .pix          (a_pix),
        .pix_filled   (a_filled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_tready) begin
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_step_reg   <= a_step;
            b_pix_reg    <= a_pix;
            b_byte_reg   <= in_present ? in_byte : '0;
            b_filled_reg <= a_filled;
            // The pixel being written back this very edge is not in the read data yet.
            b_fwd_reg    <= ram_we && (b_pix_reg == a_pix);
        end
    end

    // Frame store and pixel merge
    assign ram_we = b_valid_reg && b_adv && b_step_reg.wr;

    spfl_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (b_pix_reg),
        .wdata (merged),
        .re    (accept),
        .raddr (a_pix),
        .rdata (ram_rdata)
    );

    assign base_color = b_fwd_reg ? last_wr_reg : (b_filled_reg ? ram_rdata : '0);

    always_comb begin
        case (b_step_reg.chan)
            CH_GREEN: merged = {base_color[23:16], b_byte_reg, base_color[7:0]};
            CH_BLUE:  merged = {base_color[23:8], b_byte_reg};
            default:  merged = {b_byte_reg, base_color[15:0]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            last_wr_reg <= merged;
        end
    end

    // Result register
    always_comb begin
        m_data_next        = '0;
        m_data_next[0]     = b_step_reg.wr;
        m_data_next[6:1]   = b_step_reg.wr ? 6'(b_pix_reg) : 6'd0;
        m_data_next[8:7]   = b_step_reg.wr ? b_step_reg.chan : CH_RED;
        m_data_next[32:9]  = b_step_reg.wr ? merged : '0;
        m_data_next[33]    = b_step_reg.sync;
        m_data_next[35:34] = b_step_reg.link;
        m_data_next[36]    = b_step_reg.ind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sv/spfl_checker.sv =====
`include "serial_pixel_frame_loader_assert.svh"

module spfl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spfl_pkg::M_TDATA_W-1:0] m_tdata
);

    import spfl_pkg::*;

    logic [1:0] m_link;

    assign m_link = m_tdata[35:34];

    // A result held back by the sink keeps its value.
    `SPFL_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A write leaves the link normal, with no sync and the indicator off.
    `SPFL_ASSERT_IMPL(a_write_normal, m_tvalid && m_tdata[0], (m_link == LINK_NORMAL) && !m_tdata[33] && !m_tdata[36])

    // Without a write the pixel fields are all zero and the channel is never unused code.
    `SPFL_ASSERT_IMPL(a_no_write_zero, m_tvalid && !m_tdata[0], (m_tdata[32:1] == 32'd0))

    // The error state is consumed by the event that caused it.
    `SPFL_ASSERT_IMPL(a_no_error_state, m_tvalid, (m_link == LINK_NORMAL) || (m_link == LINK_WAIT))

    // While waiting for sync the indicator stays set and nothing is written or synced.
    `SPFL_ASSERT_IMPL(a_err_raises, m_tvalid && (m_link == LINK_WAIT), m_tdata[36] && !m_tdata[33] && !m_tdata[0])

endmodule

bind serial_pixel_frame_loader spfl_checker u_spfl_checker (.*);

// ===== bench/serial_pixel_frame_loader_tb.sv =====
module serial_pixel_frame_loader_tb;
    import spfl_pkg::*;

    localparam int PIXELS = 64;
    localparam logic [APB_ADDR_W-1:0] SYNC_ADDR = {REG_SYNC_VALUE, 2'b00};

    // One receive event as it travels in s_tdata, first field in bit 0.
    typedef struct packed {
        logic        framing;
        logic        overrun;
        logic [7:0]  rx;
        logic        present;
    } rx_event_t;

    // One result as it travels in m_tdata, first field in bit 0.
    typedef struct packed {
        logic        ind;
        logic [1:0]  link;
        logic        sync;
        logic [23:0] color;
        logic [1:0]  chan;
        logic [5:0]  pix;
        logic        wr;
    } load_result_t;

    class frame_scoreboard;
        logic [7:0]   sync_byte;
        link_t        link_st;
        logic [1:0]   color_ptr;
        logic [5:0]   pixel_ptr;
        logic         ind_level;
        logic [23:0]  pixels [PIXELS];
        load_result_t pending_results [$];
        int           errors;

        function void clear_state();
            sync_byte = SYNC_RESET;
            link_st = LINK_NORMAL;
            color_ptr = CH_RED;
            pixel_ptr = '0;
            ind_level = 1'b0;
            foreach (pixels[i]) pixels[i] = '0;
            errors = 0;
        endfunction

        function void set_sync(logic [7:0] value);
            sync_byte = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Predicts the result of one accepted event; returns 0 if the event was dropped.
        function bit note_event(rx_event_t ev);
            load_result_t r;
            logic [7:0]   rcv;
            logic [23:0]  c;
            bit           taken;
            r = '0;
            taken = 1'b1;
            rcv = ev.present ? ev.rx : 8'h00;
            // An error flag is handled on the very event that carries it.
            if (ev.overrun || ev.framing) link_st = LINK_ERROR;
            if (link_st == LINK_WAIT) begin
                if (rcv == sync_byte) begin
                    color_ptr = CH_RED;
                    pixel_ptr = '0;
                    r.sync = 1'b1;
                    link_st = LINK_NORMAL;
                end else begin
                    taken = 1'b0;
                end
            end else if (link_st == LINK_NORMAL) begin
                ind_level = 1'b0;
                if (rcv == sync_byte) begin
                    color_ptr = CH_RED;
                    pixel_ptr = '0;
                    r.sync = 1'b1;
                end else begin
                    c = pixels[pixel_ptr];
                    r.pix = pixel_ptr;
                    if (color_ptr == CH_GREEN) begin
                        r.chan = CH_GREEN;
                        c[15:8] = rcv;
                        color_ptr = CH_BLUE;
                    end else if (color_ptr == CH_BLUE) begin
                        r.chan = CH_BLUE;
                        c[7:0] = rcv;
                        color_ptr = CH_RED;
                        pixel_ptr = 6'((pixel_ptr + 1) % PIXELS);
                    end else begin
                        r.chan = CH_RED;
                        c[23:16] = rcv;
                        color_ptr = CH_GREEN;
                    end
                    pixels[r.pix] = c;
                    r.color = c;
                    r.wr = 1'b1;
                end
            end else begin
                ind_level = 1'b1;
                link_st = LINK_WAIT;
            end
            r.link = link_st;
            r.ind = ind_level;
            pending_results.push_back(r);
            return taken;
        endfunction

        function void match(string field, logic [23:0] want, logic [23:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            load_result_t got;
            load_result_t want;
            got = data[$bits(load_result_t)-1:0];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, data);
                return;
            end
            want = pending_results.pop_front();
            match("write_done", want.wr, got.wr);
            match("written_pixel", want.pix, got.pix);
            match("written_channel", want.chan, got.chan);
            match("pixel_color", want.color, got.color);
            match("sync_seen", want.sync, got.sync);
            match("link_status", want.link, got.link);
            match("error_indicator", want.ind, got.ind);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_scoreboard sb = new;
    int useful_count = 0;
    int frame_left = 0;
    bit frame_clean = 1'b0;

    serial_pixel_frame_loader i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic rx_event_t mk(bit present, logic [7:0] rx, bit ov, bit fr);
        rx_event_t ev;
        ev.present = present;
        ev.rx = rx;
        ev.overrun = ov;
        ev.framing = fr;
        return ev;
    endfunction

    // Long clean frames run past the last pixel so that the pointer wraps.
    function automatic void start_frame();
        frame_clean = ($urandom_range(99) < 20);
        frame_left = frame_clean ? $urandom_range(192, 200) : $urandom_range(1, 40);
    endfunction

    function automatic rx_event_t next_event();
        rx_event_t ev;
        int roll;
        ev = mk(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0);
        roll = $urandom_range(99);
        if (sb.link_st == LINK_WAIT) begin
            if (roll < 70) begin
                ev.rx = sb.sync_byte;
                start_frame();
            end else if (roll < 80) begin
                ev.present = 1'b0;
            end else if (roll < 88) begin
                {ev.framing, ev.overrun} = 2'($urandom_range(1, 3));
            end
        end else if (frame_left == 0) begin
            ev.rx = sb.sync_byte;
            start_frame();
        end else begin
            frame_left--;
            if (frame_clean) begin
                if (ev.rx == sb.sync_byte) ev.rx = ev.rx ^ 8'h01;
            end else if (roll < 5) begin
                {ev.framing, ev.overrun} = 2'($urandom_range(1, 3));
            end else if (roll < 9) begin
                ev.present = 1'b0;
            end else if (roll < 12) begin
                ev.rx = sb.sync_byte;
            end
        end
        return ev;
    endfunction

    task automatic send(rx_event_t ev);
        if (!(useful_count >= 600 && useful_count < 800)) begin
            while ($urandom_range(99) < 37) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - $bits(rx_event_t)){1'b0}}, ev};
        do @(posedge aclk); while (!s_tready);
        if (sb.note_event(ev)) useful_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_sync(value[7:0]);
    endtask

    // Result side: random back-pressure, one long hold-off, and a quiet stretch.
    initial begin
        int seen;
        int hold_left;
        bit held;
        seen = 0;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                seen++;
            end
            if (!held && seen == 330) begin
                held = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (seen >= 600 && seen < 800) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin
        logic [7:0] phase_sync [6];
        int target;
        sb.clear_state();
        phase_sync = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 8'h7F};
        phase_sync[2] = 8'($urandom_range(255));
        phase_sync[4] = 8'($urandom_range(255));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default sync byte: frame start, one full pixel, missing byte, errors, recovery.
        send(mk(1, 8'hFF, 0, 0));
        send(mk(1, 8'h00, 0, 0));
        send(mk(1, 8'h80, 0, 0));
        send(mk(1, 8'h7F, 0, 0));
        send(mk(0, 8'hA5, 0, 0));
        send(mk(1, 8'hFE, 0, 0));
        send(mk(1, 8'hFF, 0, 0));
        send(mk(1, 8'h12, 1, 0));
        send(mk(1, 8'h34, 0, 0));
        send(mk(0, 8'hFF, 0, 0));
        send(mk(1, 8'hFF, 0, 1));
        send(mk(1, 8'hFF, 1, 1));
        send(mk(1, 8'hFF, 0, 0));
        send(mk(1, 8'h01, 0, 0));
        send(mk(0, 8'h00, 0, 1));
        send(mk(1, 8'hFF, 0, 0));
        send(mk(1, 8'h55, 0, 0));
        send(mk(1, 8'hAA, 0, 0));

        // Sync byte of zero: a missing byte now acts as sync.
        drain();
        reg_write(SYNC_ADDR, 32'h0000_0000);
        send(mk(0, 8'h7E, 0, 0));
        send(mk(1, 8'h00, 0, 0));
        send(mk(1, 8'hFF, 0, 0));
        send(mk(1, 8'h80, 0, 0));
        send(mk(1, 8'h01, 1, 0));
        send(mk(0, 8'h33, 0, 0));
        send(mk(1, 8'hFF, 0, 0));

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            reg_write(SYNC_ADDR, {24'h0, phase_sync[phase]});
            frame_left = 0;
            target = useful_count + 205;
            while (useful_count < target) send(next_event());
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("serial_pixel_frame_loader verification clean");
        end else begin
            $display("serial_pixel_frame_loader verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("serial_pixel_frame_loader verification failed");
        $finish;
    end

endmodule

// ===== serial_pixel_frame_loader.f =====
+incdir+sv
sv/spfl_pkg.sv
sv/spfl_ram.sv
sv/spfl_ctrl.sv
sv/serial_pixel_frame_loader.sv
sv/spfl_checker.sv
bench/serial_pixel_frame_loader_tb.sv
